/* sv/tcit_pkg.sv */
// Shared constants, types and codes of the timed constraint interval table.
`timescale 1ns / 1ps

package tcit_pkg;

	localparam int LOCATIONS      = 4096;
	localparam int SLOTS          = 8;
	localparam int KIND_BITS      = 3;
	localparam int LOC_FIELD_BITS = 12;
	localparam int TF_BITS        = 16;

	localparam int LOC_BITS      = $clog2(LOCATIONS);
	localparam int SLOT_IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_BITS      = $clog2(SLOTS + 1);
	localparam int ADDR_BITS     = $clog2(LOCATIONS * SLOTS);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef logic [TF_BITS-1:0] tval_t;

	localparam logic [KIND_BITS-1:0] KIND_INSERT  = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_TMAX    = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_TMIN    = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_BLOCKED = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_HOLD    = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_HORIZON = 3'd5;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_TMAX,
		OP_TMIN,
		OP_BLOCKED,
		OP_HOLD,
		OP_HORIZON
	} op_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_CNT,
		ST_DEC,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} st_t;

	typedef struct packed {
		op_t                 op;
		logic                loc_ok;
		logic [LOC_BITS-1:0] loc;
		tval_t               t_lo;
		tval_t               t_hi;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qlink_t;

	typedef struct packed {
		logic pop;
		logic init_done;
	} bstat_t;

endpackage

/* sv/tcit_if.sv */
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps

interface tcit_in_if import tcit_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [KIND_BITS-1:0]      kind;
	logic [LOC_FIELD_BITS-1:0] location;
	tval_t                     time_low;
	tval_t                     time_high;

	modport source (output valid, kind, location, time_low, time_high, input ready);
	modport sink (input valid, kind, location, time_low, time_high, output ready);
endinterface

interface tcit_out_if import tcit_pkg::*;;
	logic  valid;
	logic  ready;
	logic  blocked;
	tval_t time_result;
	logic  overflow;

	modport source (output valid, blocked, time_result, overflow, input ready);
	modport sink (input valid, blocked, time_result, overflow, output ready);
endinterface

/* sv/tcit_front.sv */
// Front end: accepts items, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module tcit_front import tcit_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tcit_in_if.sink item,
	output qlink_t head,
	input  bstat_t bstat
);

	cmd_t                 cmd_in;
	logic                 push;
	cmd_t                 fifo_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;

	always_comb begin
		cmd_in.loc_ok = (32'(item.location) < LOCATIONS);
		cmd_in.loc    = LOC_BITS'(item.location);
		cmd_in.t_lo   = item.time_low;
		cmd_in.t_hi   = item.time_high;
		unique case (item.kind)
			KIND_INSERT:  cmd_in.op = cmd_in.loc_ok ? OP_INSERT : OP_NONE;
			KIND_TMAX:    cmd_in.op = OP_TMAX;
			KIND_TMIN:    cmd_in.op = OP_TMIN;
			KIND_BLOCKED: cmd_in.op = cmd_in.loc_ok ? OP_BLOCKED : OP_NONE;
			KIND_HOLD:    cmd_in.op = OP_HOLD;
			KIND_HORIZON: cmd_in.op = OP_HORIZON;
			default:      cmd_in.op = OP_NONE;
		endcase
	end

	assign item.ready = (fill_q != (QPTR_BITS + 1)'(QUEUE_DEPTH)) && bstat.init_done;
	assign push       = item.valid && item.ready;
	assign head.valid = (fill_q != '0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (bstat.pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !bstat.pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && bstat.pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* sv/tcit_back.sv */
// Back end: slot count and interval memories, scan sequencer and result register.
`timescale 1ns / 1ps

module tcit_back import tcit_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  tval_t         cfg_wr_data,
	input  qlink_t        head,
	output bstat_t        bstat,
	tcit_out_if.source    result
);

	st_t                      st_q, st_d;
	cmd_t                     cmd_q;
	logic [LOC_BITS-1:0]      clr_idx_q;
	logic [CNT_BITS-1:0]      cnt_mem [LOCATIONS];
	logic [CNT_BITS-1:0]      cnt_rd_q;
	logic [2*TF_BITS-1:0]     store_mem [LOCATIONS * SLOTS];
	logic [2*TF_BITS-1:0]     rd_data_q;
	logic                     rd_vld_q;
	logic [SLOT_IDX_BITS-1:0] idx_q;
	tval_t                    ch_q, minl_q, maxl_q, avh_q;
	logic                     res_blk_q, res_ovf_q;
	tval_t                    res_time_q;
	logic                     out_valid_q, out_blk_q, out_ovf_q;
	tval_t                    out_time_q;

	logic                     out_load;
	logic                     mem_op;
	logic                     full;
	logic                     scan_last;
	logic                     ins_go;
	logic [ADDR_BITS-1:0]     base;
	logic [ADDR_BITS-1:0]     rd_addr;
	logic [ADDR_BITS-1:0]     wr_addr;
	tval_t                    rd_start, rd_end;
	logic                     hit;
	tval_t                    tmin_v;
	tval_t                    hz_a, hz_b, hz;
	logic                     cnt_we;
	logic [LOC_BITS-1:0]      cnt_wa;
	logic [CNT_BITS-1:0]      cnt_wd;

	assign mem_op    = (cmd_q.op == OP_INSERT) || (cmd_q.op == OP_BLOCKED)
	                   || ((cmd_q.op == OP_HOLD) && cmd_q.loc_ok);
	assign full      = (cnt_rd_q >= CNT_BITS'(SLOTS));
	assign scan_last = (CNT_BITS'(idx_q) == cnt_rd_q - CNT_BITS'(1));
	assign ins_go    = (st_q == ST_DEC) && (cmd_q.op == OP_INSERT) && !full;
	assign base      = ADDR_BITS'(ADDR_BITS'(cmd_q.loc) * ADDR_BITS'(SLOTS));
	assign rd_addr   = base + ADDR_BITS'(idx_q);
	assign wr_addr   = base + ADDR_BITS'(cnt_rd_q);
	assign rd_start  = rd_data_q[TF_BITS-1:0];
	assign rd_end    = rd_data_q[2*TF_BITS-1:TF_BITS];
	assign hit       = (rd_start <= cmd_q.t_lo) && ((cmd_q.t_lo < rd_end) || (rd_end == '1));
	assign tmin_v    = (cmd_q.t_lo == '1) ? '1 : cmd_q.t_lo + 1'b1;
	assign hz_a      = (ch_q > avh_q) ? ch_q : avh_q;
	assign hz_b      = (hz_a > minl_q) ? hz_a : minl_q;
	assign hz        = ((maxl_q != '1) && (maxl_q > hz_b)) ? maxl_q : hz_b;

	assign cnt_we = (st_q == ST_CLR) || ins_go;
	assign cnt_wa = (st_q == ST_CLR) ? clr_idx_q : cmd_q.loc;
	assign cnt_wd = (st_q == ST_CLR) ? '0 : cnt_rd_q + 1'b1;

	always_comb begin
		st_d            = st_q;
		bstat.pop       = 1'b0;
		bstat.init_done = (st_q != ST_CLR);
		out_load        = 1'b0;
		unique case (st_q)
			ST_CLR: begin
				if (clr_idx_q == LOC_BITS'(LOCATIONS - 1)) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head.valid) begin
					bstat.pop = 1'b1;
					st_d      = ST_CNT;
				end
			end
			ST_CNT: begin
				st_d = mem_op ? ST_DEC : ST_OUT;
			end
			ST_DEC: begin
				if ((cmd_q.op == OP_INSERT) || (cnt_rd_q == '0)) begin
					st_d = ST_OUT;
				end else begin
					st_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_idx_q   <= '0;
			ch_q        <= '0;
			minl_q      <= '0;
			maxl_q      <= '1;
			avh_q       <= '0;
			out_valid_q <= 1'b0;
			rd_vld_q    <= 1'b0;
		end else begin
			st_q     <= st_d;
			rd_vld_q <= (st_q == ST_SCAN);
			if (st_q == ST_CLR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cfg_wr_en) begin
				avh_q <= cfg_wr_data;
			end
			if (st_q == ST_CNT) begin
				if ((cmd_q.op == OP_TMAX) && (cmd_q.t_lo < maxl_q)) maxl_q <= cmd_q.t_lo;
				if ((cmd_q.op == OP_TMIN) && (tmin_v > minl_q)) minl_q <= tmin_v;
			end
			if (ins_go) begin
				if ((cmd_q.t_hi != '1) && (cmd_q.t_hi > ch_q)) begin
					ch_q <= cmd_q.t_hi;
				end else if ((cmd_q.t_hi == '1) && (cmd_q.t_lo > ch_q)) begin
					ch_q <= cmd_q.t_lo;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[cmd_q.loc];
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= store_mem[rd_addr];
		if (ins_go) begin
			store_mem[wr_addr] <= {cmd_q.t_hi, cmd_q.t_lo};
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_IDLE) && head.valid) begin
			cmd_q <= head.cmd;
		end
		if (st_q == ST_DEC) begin
			idx_q <= '0;
		end else if (st_q == ST_SCAN) begin
			idx_q <= idx_q + 1'b1;
		end
		if (st_q == ST_CNT) begin
			res_blk_q <= 1'b0;
			res_ovf_q <= 1'b0;
			if (cmd_q.op == OP_HORIZON) begin
				res_time_q <= hz;
			end else if (cmd_q.op == OP_HOLD) begin
				res_time_q <= cmd_q.t_lo;
			end else begin
				res_time_q <= '0;
			end
		end else if (st_q == ST_DEC) begin
			res_blk_q  <= 1'b0;
			res_ovf_q  <= (cmd_q.op == OP_INSERT) && full;
			res_time_q <= (cmd_q.op == OP_HOLD) ? cmd_q.t_lo : '0;
		end else if (rd_vld_q) begin
			if ((cmd_q.op == OP_BLOCKED) && hit) res_blk_q <= 1'b1;
			if ((cmd_q.op == OP_HOLD) && (rd_end > res_time_q)) res_time_q <= rd_end;
		end
		if (out_load) begin
			out_blk_q  <= res_blk_q;
			out_ovf_q  <= res_ovf_q;
			out_time_q <= res_time_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.blocked     = out_blk_q;
	assign result.overflow    = out_ovf_q;
	assign result.time_result = out_time_q;

endmodule

/* sv/timed_constraint_interval_table_top.sv */
// Top level of the timed constraint interval table.
// Items arrive on the item channel (valid/ready): kind, location, time_low,
// time_high. Each item gives exactly one transaction on the result channel:
// blocked, time_result and overflow, with fields that do not apply at zero.
// avoidance_horizon is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce.
// A two-entry command queue parts the front end from the back end.
// Register-only kinds go from IDLE through CNT to OUT; inserts and empty
// locations also pass DEC; queries over stored intervals add SCAN and DRAIN.
// One item is in service at a time: throughput is set by the slot scan, one
// interval read from the interval memory per cycle, and by receiver stalls.
// After reset the slot count memory is cleared, one location per cycle, over
// all 4096 locations; item.ready stays low during that pass.
// When the receiver stalls the result is held in the output register; the
// next item still runs up to its result; the queue takes items until full.
`timescale 1ns / 1ps

module timed_constraint_interval_table_top import tcit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  tval_t       cfg_wr_data,
	tcit_in_if.sink     item,
	tcit_out_if.source  result
);

	qlink_t hlink;
	bstat_t bstat;

	tcit_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.head   (hlink),
		.bstat  (bstat)
	);

	tcit_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head        (hlink),
		.bstat       (bstat),
		.result      (result)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!bstat.init_done |-> !item.ready)
		else $error("item ready during clearing pass");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> hlink.valid)
		else $error("queue popped while empty");

	a_one_field_used: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($countones({result.blocked, result.overflow,
		|result.time_result}) <= 1))
		else $error("result carries more than one kind of answer");

endmodule
